/* rtl/lfvf_pkg.sv */
// Shared widths, constants and types for the Lax-Friedrichs velocity flux pipeline.
package lfvf_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int NORM_WIDTH = 18;
  localparam int NORM_FRAC  = 16;
  localparam int NUM_STAGES = 6;

  localparam int DOT_PW = DATA_WIDTH + NORM_WIDTH;
  localparam int DOT_SW = DOT_PW + 2;
  localparam int DOT_TW = DOT_SW - NORM_FRAC;
  localparam int SPD_W  = DATA_WIDTH - 1;
  localparam int DIFF_W = DATA_WIDTH + 1;
  localparam int AP_W   = 2 * DATA_WIDTH;
  localparam int ASUM_W = AP_W + 1;
  localparam int DP_W   = DIFF_W + DATA_WIDTH;
  localparam int Q_W    = DP_W + 1;
  localparam int SH_W   = Q_W - FRAC_BITS;

  localparam logic signed [DOT_TW-1:0] DOT_HI = {{(DOT_TW - SPD_W){1'b0}}, {SPD_W{1'b1}}};
  localparam logic signed [DOT_TW-1:0] DOT_LO = -DOT_HI;

  localparam logic signed [DATA_WIDTH-1:0] FLUX_MAX = {1'b0, {SPD_W{1'b1}}};
  localparam logic signed [DATA_WIDTH-1:0] FLUX_MIN = {1'b1, {SPD_W{1'b0}}};

  typedef logic signed [DATA_WIDTH-1:0] data_t;
  typedef logic signed [NORM_WIDTH-1:0] norm_t;
  typedef logic        [SPD_W-1:0]      spd_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } lfvf_adv_t;

endpackage

/* rtl/lfvf_if.sv */
// Valid/ready channel interfaces for the flux block input and result.
interface lfvf_in_if;
  logic                  valid;
  logic                  ready;
  lfvf_pkg::data_t       left_u;
  lfvf_pkg::data_t       left_v;
  lfvf_pkg::data_t       left_w;
  lfvf_pkg::data_t       right_u;
  lfvf_pkg::data_t       right_v;
  lfvf_pkg::data_t       right_w;
  lfvf_pkg::norm_t       normal_x;
  lfvf_pkg::norm_t       normal_y;
  lfvf_pkg::norm_t       normal_z;

  modport source (
    output valid, left_u, left_v, left_w, right_u, right_v, right_w,
           normal_x, normal_y, normal_z,
    input  ready
  );
  modport sink (
    input  valid, left_u, left_v, left_w, right_u, right_v, right_w,
           normal_x, normal_y, normal_z,
    output ready
  );
endinterface

interface lfvf_out_if;
  logic            valid;
  logic            ready;
  lfvf_pkg::data_t flux_u;
  lfvf_pkg::data_t flux_v;
  lfvf_pkg::data_t flux_w;
  logic            saturated;

  modport source (
    output valid, flux_u, flux_v, flux_w, saturated,
    input  ready
  );
  modport sink (
    input  valid, flux_u, flux_v, flux_w, saturated,
    output ready
  );
endinterface

/* rtl/lfvf_dot.sv */
// Normal velocity of one side: dot product with the face normal, shift and symmetric clip.
module lfvf_dot (
  input  logic                clk,
  input  lfvf_pkg::lfvf_adv_t adv,
  input  lfvf_pkg::data_t     c_x,
  input  lfvf_pkg::data_t     c_y,
  input  lfvf_pkg::data_t     c_z,
  input  lfvf_pkg::norm_t     n_x,
  input  lfvf_pkg::norm_t     n_y,
  input  lfvf_pkg::norm_t     n_z,
  output lfvf_pkg::data_t     spd
);

  logic signed [lfvf_pkg::DOT_PW-1:0] p0_r, p1_r, p2_r;
  logic signed [lfvf_pkg::DOT_PW-1:0] p0_nxt, p1_nxt, p2_nxt;
  logic signed [lfvf_pkg::DOT_SW-1:0] sum;
  logic signed [lfvf_pkg::DOT_TW-1:0] sh;
  lfvf_pkg::data_t                    spd_r, spd_nxt;

  assign p0_nxt = lfvf_pkg::DOT_PW'(c_x) * lfvf_pkg::DOT_PW'(n_x);
  assign p1_nxt = lfvf_pkg::DOT_PW'(c_y) * lfvf_pkg::DOT_PW'(n_y);
  assign p2_nxt = lfvf_pkg::DOT_PW'(c_z) * lfvf_pkg::DOT_PW'(n_z);

  always_comb begin
    sum = lfvf_pkg::DOT_SW'(p0_r) + lfvf_pkg::DOT_SW'(p1_r) + lfvf_pkg::DOT_SW'(p2_r);
    sh  = lfvf_pkg::DOT_TW'(sum >>> lfvf_pkg::NORM_FRAC);
    if (sh > lfvf_pkg::DOT_HI) begin
      spd_nxt = lfvf_pkg::DATA_WIDTH'(lfvf_pkg::DOT_HI);
    end else if (sh < lfvf_pkg::DOT_LO) begin
      spd_nxt = lfvf_pkg::DATA_WIDTH'(lfvf_pkg::DOT_LO);
    end else begin
      spd_nxt = lfvf_pkg::DATA_WIDTH'(sh);
    end
  end

  always_ff @(posedge clk) begin
    if (adv.en[0]) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
    end
    if (adv.en[1]) begin
      spd_r <= spd_nxt;
    end
  end

  assign spd = spd_r;

endmodule

/* rtl/lfvf_comp.sv */
// Flux datapath of one velocity component: products, wave-speed term, rounding, saturation.
module lfvf_comp (
  input  logic                clk,
  input  lfvf_pkg::lfvf_adv_t adv,
  input  lfvf_pkg::data_t     cl,
  input  lfvf_pkg::data_t     cr,
  input  lfvf_pkg::data_t     dl,
  input  lfvf_pkg::data_t     dr,
  input  lfvf_pkg::spd_t      m,
  output lfvf_pkg::data_t     flux,
  output logic                clip
);

  lfvf_pkg::data_t                        cl1_r, cr1_r, cl2_r, cr2_r;
  logic signed [lfvf_pkg::DIFF_W-1:0]     df2_r, df3_r, df2_nxt;
  logic signed [lfvf_pkg::AP_W-1:0]       al3_r, ar3_r, al3_nxt, ar3_nxt;
  logic signed [lfvf_pkg::ASUM_W-1:0]     asum;
  logic signed [lfvf_pkg::ASUM_W-2:0]     ah4_r, ah4_nxt;
  logic signed [lfvf_pkg::DP_W-1:0]       dp4_r, dp4_nxt;
  logic signed [lfvf_pkg::Q_W-1:0]        q5_r, q5_nxt;
  logic signed [lfvf_pkg::SH_W-1:0]       sh;
  logic [lfvf_pkg::SH_W-lfvf_pkg::DATA_WIDTH:0] hi;
  lfvf_pkg::data_t                        flux_r, flux_nxt;
  logic                                   clip_r, clip_nxt;

  assign df2_nxt = lfvf_pkg::DIFF_W'(cl1_r) - lfvf_pkg::DIFF_W'(cr1_r);
  assign al3_nxt = lfvf_pkg::AP_W'(cl2_r) * lfvf_pkg::AP_W'(dl);
  assign ar3_nxt = lfvf_pkg::AP_W'(cr2_r) * lfvf_pkg::AP_W'(dr);
  assign asum    = lfvf_pkg::ASUM_W'(al3_r) + lfvf_pkg::ASUM_W'(ar3_r);
  assign ah4_nxt = (lfvf_pkg::ASUM_W-1)'(asum >>> 1);
  assign dp4_nxt = lfvf_pkg::DP_W'(df3_r) * lfvf_pkg::DP_W'($signed({1'b0, m}));
  assign q5_nxt  = lfvf_pkg::Q_W'(ah4_r) + lfvf_pkg::Q_W'(dp4_r);

  always_comb begin
    sh = lfvf_pkg::SH_W'(q5_r >>> lfvf_pkg::FRAC_BITS);
    hi = sh[lfvf_pkg::SH_W-1:lfvf_pkg::DATA_WIDTH-1];
    if ((&hi) || !(|hi)) begin
      flux_nxt = sh[lfvf_pkg::DATA_WIDTH-1:0];
      clip_nxt = 1'b0;
    end else if (sh[lfvf_pkg::SH_W-1]) begin
      flux_nxt = lfvf_pkg::FLUX_MIN;
      clip_nxt = 1'b1;
    end else begin
      flux_nxt = lfvf_pkg::FLUX_MAX;
      clip_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv.en[0]) begin
      cl1_r <= cl;
      cr1_r <= cr;
    end
    if (adv.en[1]) begin
      cl2_r <= cl1_r;
      cr2_r <= cr1_r;
      df2_r <= df2_nxt;
    end
    if (adv.en[2]) begin
      al3_r <= al3_nxt;
      ar3_r <= ar3_nxt;
      df3_r <= df2_r;
    end
    if (adv.en[3]) begin
      ah4_r <= ah4_nxt;
      dp4_r <= dp4_nxt;
    end
    if (adv.en[4]) begin
      q5_r <= q5_nxt;
    end
    if (adv.en[5]) begin
      flux_r <= flux_nxt;
      clip_r <= clip_nxt;
    end
  end

  assign flux = flux_r;
  assign clip = clip_r;

endmodule

/* rtl/lax_friedrichs_velocity_flux.sv */
// Top level: pipelined local Lax-Friedrichs flux for the convective velocity term.
//
// in_chan carries one face point per transaction: left and right velocity
// vectors (signed Q16.16) and the face normal (signed Q2.16). out_chan returns
// the three flux components (signed Q16.16, saturated) and a flag that is set
// when any of them was clipped.
// The datapath is six register stages: normal-velocity products, dot-product
// sum and clip, component products with the wave speed max, sum and wave-speed
// product, final add, floor shift and saturation into the output register.
// The accepting edge loads the first stage; out_chan.valid rises when the
// transaction reaches the output register and stays there until out_chan takes it.
// Throughput is one transaction per cycle while out_chan.ready is high; every
// stage carries its own valid bit and loads whenever the stage below is empty or moving.
// When the receiver stalls, the output register holds its transaction and the
// pipeline fills behind it; in_chan.ready drops only once all six stages hold
// a transaction. Nothing is dropped or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; no configuration.
module lax_friedrichs_velocity_flux (
  input  logic        clk,
  input  logic        rst_n,
  lfvf_in_if.sink     in_chan,
  lfvf_out_if.source  out_chan
);

  logic [lfvf_pkg::NUM_STAGES-1:0] v_r, v_nxt, v_in;
  logic [lfvf_pkg::NUM_STAGES:0]   rdy;
  lfvf_pkg::lfvf_adv_t             adv;
  lfvf_pkg::data_t                 dl, dr, abs_l, abs_r;
  lfvf_pkg::spd_t                  m3_r, m3_nxt;
  lfvf_pkg::data_t                 fu, fv, fw;
  logic                            cu, cv, cw;

  always_comb begin
    v_in = {v_r[lfvf_pkg::NUM_STAGES-2:0], in_chan.valid};
    rdy[lfvf_pkg::NUM_STAGES] = out_chan.ready;
    for (int i = lfvf_pkg::NUM_STAGES - 1; i >= 0; i--) begin
      rdy[i] = !v_r[i] || rdy[i+1];
    end
    for (int i = 0; i < lfvf_pkg::NUM_STAGES; i++) begin
      v_nxt[i]  = rdy[i] ? v_in[i] : v_r[i];
      adv.en[i] = rdy[i] && v_in[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  lfvf_dot u_dot_l (
    .clk (clk),
    .adv (adv),
    .c_x (in_chan.left_u),
    .c_y (in_chan.left_v),
    .c_z (in_chan.left_w),
    .n_x (in_chan.normal_x),
    .n_y (in_chan.normal_y),
    .n_z (in_chan.normal_z),
    .spd (dl)
  );

  lfvf_dot u_dot_r (
    .clk (clk),
    .adv (adv),
    .c_x (in_chan.right_u),
    .c_y (in_chan.right_v),
    .c_z (in_chan.right_w),
    .n_x (in_chan.normal_x),
    .n_y (in_chan.normal_y),
    .n_z (in_chan.normal_z),
    .spd (dr)
  );

  // normal speeds are clipped symmetric, so the magnitude fits SPD_W bits
  always_comb begin
    abs_l  = dl[lfvf_pkg::DATA_WIDTH-1] ? -dl : dl;
    abs_r  = dr[lfvf_pkg::DATA_WIDTH-1] ? -dr : dr;
    m3_nxt = (abs_r[lfvf_pkg::SPD_W-1:0] > abs_l[lfvf_pkg::SPD_W-1:0]) ?
             abs_r[lfvf_pkg::SPD_W-1:0] : abs_l[lfvf_pkg::SPD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv.en[2]) begin
      m3_r <= m3_nxt;
    end
  end

  lfvf_comp u_comp_u (
    .clk  (clk),
    .adv  (adv),
    .cl   (in_chan.left_u),
    .cr   (in_chan.right_u),
    .dl   (dl),
    .dr   (dr),
    .m    (m3_r),
    .flux (fu),
    .clip (cu)
  );

  lfvf_comp u_comp_v (
    .clk  (clk),
    .adv  (adv),
    .cl   (in_chan.left_v),
    .cr   (in_chan.right_v),
    .dl   (dl),
    .dr   (dr),
    .m    (m3_r),
    .flux (fv),
    .clip (cv)
  );

  lfvf_comp u_comp_w (
    .clk  (clk),
    .adv  (adv),
    .cl   (in_chan.left_w),
    .cr   (in_chan.right_w),
    .dl   (dl),
    .dr   (dr),
    .m    (m3_r),
    .flux (fw),
    .clip (cw)
  );

  assign in_chan.ready      = rdy[0];
  assign out_chan.valid     = v_r[lfvf_pkg::NUM_STAGES-1];
  assign out_chan.flux_u    = fu;
  assign out_chan.flux_v    = fv;
  assign out_chan.flux_w    = fw;
  assign out_chan.saturated = cu | cv | cw;

endmodule
